/* design/rgb_edge_mask_3x3_defines.svh */
// ----------------------------------------------------------------------------
// rgb_edge_mask_3x3 assertion macros
// Shared concurrent assertion forms for the edge mask block.
// ----------------------------------------------------------------------------
`ifndef RGB_EDGE_MASK_3X3_DEFINES_SVH
`define RGB_EDGE_MASK_3X3_DEFINES_SVH

// same-cycle implication
`define RGBEM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbem: same-cycle check failed");

// next-cycle implication
`define RGBEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbem: next-cycle check failed");

`endif

/* design/rgbem_pkg.sv */
// ----------------------------------------------------------------------------
// rgbem_pkg
// Types and constants shared by the rgb edge mask block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbem_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MIN_DIM       = 3;
  localparam int ROW_W         = 10;  // row counter, 0 .. MAX_HEIGHT-1
  localparam int HGT_W         = 11;  // effective height, up to MAX_HEIGHT
  localparam int CFG_DIM_W     = 11;
  localparam int KIND_W        = 3;
  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 4;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 11'd480;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MASK   = 2'd2
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    MASK_LAPLACE4 = 3'd0,
    MASK_LAPLACE8 = 3'd1,
    MASK_VPREWITT = 3'd2,
    MASK_HPREWITT = 3'd3,
    MASK_PASS     = 3'd4
  } mask_kind_t;

  typedef logic [PIX_W-1:0] pix_t;
  // [row][col], row 0 is the oldest line, col 2 the newest pixel
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;
    logic            drain;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] red_out;
    logic            frame_end;
  } out_item_t;

  typedef struct packed {
    logic write;      // store pixel into the line memories
    logic shift;      // window takes a new column
    logic use_vc;     // new column comes from the drain read port
    logic vc_ok;      // drain column lies inside the frame
    logic emit;       // transaction produces a result
    logic interior;   // result pixel is off the border
    logic frame_end;  // result is the last pixel of the frame
  } ctrl_t;

endpackage

`default_nettype wire

/* design/rgbem_stream_if.sv */
// ----------------------------------------------------------------------------
// rgbem stream interfaces
// Valid/ready channels for input pixels and result pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rgbem_in_if;
  logic                 valid;
  logic                 ready;
  rgbem_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rgbem_out_if;
  logic                 valid;
  logic                 ready;
  rgbem_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/rgb_edge_mask_3x3.sv */
// ----------------------------------------------------------------------------
// rgb_edge_mask_3x3
// 3x3 Laplace / Prewitt edge mask over a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, sustained while results.ready keeps the output moving.
// Each transaction passes an input register, the window shift and mask arithmetic,
// and the result register. Results trail the input by frame_width+1 pixels;
// after the last pixel of a frame that many drain transactions (drain=1) push
// the tail out, the first drain only once the input is back at the start of a
// frame. Two line memories of MAX_WIDTH x 24 bits hold the previous rows; they
// need no clearing pass after reset. A write to frame_width or frame_height
// restarts the frame and drops pending results; write registers only while the
// block is idle.
`timescale 1ns / 1ps
`default_nettype none

module rgb_edge_mask_3x3 #(
  parameter int MAX_WIDTH = rgbem_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  rgbem_in_if.sink                           pixels,
  rgbem_out_if.source                        results,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rgbem_pkg::APB_AW-1:0]  paddr,
  input  wire logic [rgbem_pkg::APB_DW-1:0]  pwdata,
  output logic      [rgbem_pkg::APB_DW-1:0]  prdata,
  output logic                               pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 2);
  localparam int CH = rgbem_pkg::CH_W;

  logic                           in_valid;
  rgbem_pkg::in_item_t            in_item;
  logic                           out_valid;
  rgbem_pkg::out_item_t           out_item;
  logic                           proceed;
  logic                           go;

  logic [CW-1:0]                  eff_w;
  logic [rgbem_pkg::HGT_W-1:0]    eff_h;
  logic [rgbem_pkg::KIND_W-1:0]   kind;
  logic                           restart;

  rgbem_pkg::ctrl_t               ctl;
  logic [AW-1:0]                  wr_addr;
  logic [AW-1:0]                  rd_addr_col;
  logic [AW-1:0]                  rd_addr_vc;

  rgbem_pkg::pix_t                pix;
  rgbem_pkg::pix_t                mid_a, mid_b, top_a, top_b;
  rgbem_pkg::pix_t                col_top, col_mid, col_bot;
  rgbem_pkg::win_t                win, win_next;
  rgbem_pkg::pix_t                mask_pix;

  // input register
  assign proceed      = !out_valid || results.ready;
  assign go           = in_valid && proceed;
  assign pixels.ready = !in_valid || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixels.ready) begin
      in_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.ready && pixels.valid) begin
      in_item <= pixels.payload;
    end
  end

  assign pix = {in_item.red_in, in_item.green_in, in_item.blue_in};

  rgbem_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .kind    (kind),
    .restart (restart)
  );

  rgbem_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .drain       (in_item.drain),
    .restart     (restart),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .ctl         (ctl),
    .wr_addr     (wr_addr),
    .rd_addr_col (rd_addr_col),
    .rd_addr_vc  (rd_addr_vc)
  );

  // most recent stored line
  rgbem_line_mem #(.DEPTH(MAX_WIDTH)) u_line_mid (
    .clk     (clk),
    .we      (ctl.write),
    .waddr   (wr_addr),
    .wdata   (pix),
    .raddr_a (rd_addr_col),
    .raddr_b (rd_addr_vc),
    .rdata_a (mid_a),
    .rdata_b (mid_b)
  );

  // line before that
  rgbem_line_mem #(.DEPTH(MAX_WIDTH)) u_line_top (
    .clk     (clk),
    .we      (ctl.write),
    .waddr   (wr_addr),
    .wdata   (mid_a),
    .raddr_a (rd_addr_col),
    .raddr_b (rd_addr_vc),
    .rdata_a (top_a),
    .rdata_b (top_b)
  );

  always_comb begin
    if (ctl.use_vc) begin
      col_top = ctl.vc_ok ? top_b : '0;
      col_mid = ctl.vc_ok ? mid_b : '0;
      col_bot = '0;
    end else begin
      col_top = top_a;
      col_mid = mid_a;
      col_bot = pix;
    end
  end

  always_comb begin
    win_next = win;
    if (ctl.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_next[r][0] = win[r][1];
        win_next[r][1] = win[r][2];
      end
      win_next[0][2] = col_top;
      win_next[1][2] = col_mid;
      win_next[2][2] = col_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else begin
      win <= win_next;
    end
  end

  rgbem_mask u_mask (
    .win      (win_next),
    .kind     (kind),
    .interior (ctl.interior),
    .pix      (mask_pix)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_item.blue_out  <= mask_pix[CH-1:0];
      out_item.green_out <= mask_pix[2*CH-1:CH];
      out_item.red_out   <= mask_pix[3*CH-1:2*CH];
      out_item.frame_end <= ctl.frame_end;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_item;

endmodule

`default_nettype wire

/* design/rgbem_cfg.sv */
// ----------------------------------------------------------------------------
// rgbem_cfg
// APB register file: frame geometry and mask select, with clamped views.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbem_cfg #(
  parameter int MAX_WIDTH = rgbem_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rgbem_pkg::APB_AW-1:0]    paddr,
  input  wire logic [rgbem_pkg::APB_DW-1:0]    pwdata,
  output logic      [rgbem_pkg::APB_DW-1:0]    prdata,
  output logic                                 pready,
  output logic      [$clog2(MAX_WIDTH+2)-1:0]  eff_w,
  output logic      [rgbem_pkg::HGT_W-1:0]     eff_h,
  output logic      [rgbem_pkg::KIND_W-1:0]    kind,
  output logic                                 restart
);

  localparam int CW  = $clog2(MAX_WIDTH + 2);
  localparam int HW  = rgbem_pkg::HGT_W;
  localparam int DW  = rgbem_pkg::APB_DW;
  localparam int DIM = rgbem_pkg::CFG_DIM_W;
  localparam int KW  = rgbem_pkg::KIND_W;

  logic [DIM-1:0]             frame_width;
  logic [DIM-1:0]             frame_height;
  logic [KW-1:0]              mask_kind;
  logic                       wr;
  rgbem_pkg::reg_idx_t        idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = rgbem_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgbem_pkg::WIDTH_RST;
      frame_height <= rgbem_pkg::HEIGHT_RST;
      mask_kind    <= rgbem_pkg::MASK_LAPLACE4;
    end else if (wr) begin
      unique case (idx)
        rgbem_pkg::REG_WIDTH:  frame_width  <= pwdata[DIM-1:0];
        rgbem_pkg::REG_HEIGHT: frame_height <= pwdata[DIM-1:0];
        rgbem_pkg::REG_MASK:   mask_kind    <= pwdata[KW-1:0];
        default: ;
      endcase
    end
  end

  // geometry writes restart the frame
  assign restart = wr && ((idx == rgbem_pkg::REG_WIDTH) || (idx == rgbem_pkg::REG_HEIGHT));

  always_comb begin
    unique case (idx)
      rgbem_pkg::REG_WIDTH:  prdata = DW'(frame_width);
      rgbem_pkg::REG_HEIGHT: prdata = DW'(frame_height);
      rgbem_pkg::REG_MASK:   prdata = DW'(mask_kind);
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    if (int'(frame_width) < rgbem_pkg::MIN_DIM) begin
      eff_w = CW'(rgbem_pkg::MIN_DIM);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width);
    end
    if (int'(frame_height) < rgbem_pkg::MIN_DIM) begin
      eff_h = HW'(rgbem_pkg::MIN_DIM);
    end else if (int'(frame_height) > rgbem_pkg::MAX_HEIGHT) begin
      eff_h = HW'(rgbem_pkg::MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height);
    end
  end

  assign kind = mask_kind;

endmodule

`default_nettype wire

/* design/rgbem_line_mem.sv */
// ----------------------------------------------------------------------------
// rgbem_line_mem
// One line of pixels: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbem_line_mem #(
  parameter int DEPTH = rgbem_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire rgbem_pkg::pix_t          wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output rgbem_pkg::pix_t               rdata_a,
  output rgbem_pkg::pix_t               rdata_b
);

  rgbem_pkg::pix_t mem [DEPTH];

  // write-first on address match
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
  end

endmodule

`default_nettype wire

/* design/rgbem_ctrl.sv */
// ----------------------------------------------------------------------------
// rgbem_ctrl
// Input/output position counters, pending count and line memory addressing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_edge_mask_3x3_defines.svh"

module rgbem_ctrl #(
  parameter int MAX_WIDTH = rgbem_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             go,
  input  wire logic                             drain,
  input  wire logic                             restart,
  input  wire logic [$clog2(MAX_WIDTH+2)-1:0]   eff_w,
  input  wire logic [rgbem_pkg::HGT_W-1:0]      eff_h,
  output rgbem_pkg::ctrl_t                      ctl,
  output logic      [$clog2(MAX_WIDTH)-1:0]     wr_addr,
  output logic      [$clog2(MAX_WIDTH)-1:0]     rd_addr_col,
  output logic      [$clog2(MAX_WIDTH)-1:0]     rd_addr_vc
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 2);
  localparam int RW = rgbem_pkg::ROW_W;
  localparam int HW = rgbem_pkg::HGT_W;

  logic [AW-1:0] in_col, in_col_next;
  logic [RW-1:0] in_row, in_row_next;
  logic [CW-1:0] pend, pend_next;
  logic [AW-1:0] out_col, out_col_next;
  logic [RW-1:0] out_row, out_row_next;

  logic          pos0;
  logic          drain_live;
  logic          pend_full;
  logic [CW-1:0] w_plus1;
  logic [CW-1:0] w_minus1;
  logic [HW-1:0] h_minus1;
  logic [CW-1:0] vc;
  logic [CW-1:0] vc_next;

  assign w_plus1  = eff_w + CW'(1);
  assign w_minus1 = eff_w - CW'(1);
  assign h_minus1 = eff_h - HW'(1);
  assign pos0       = (in_col == '0) && (in_row == '0);
  assign drain_live = pos0 && (pend != '0);
  // a pixel only yields a result once a line and one pixel are queued
  assign pend_full  = pend >= w_plus1;
  assign vc         = w_plus1 - pend;

  always_comb begin
    ctl.write     = go && !drain;
    ctl.shift     = go && (!drain || drain_live);
    ctl.use_vc    = drain;
    ctl.vc_ok     = vc < eff_w;
    ctl.emit      = go && (drain ? drain_live : pend_full);
    ctl.interior  = !drain && (in_row >= RW'(2)) && (in_col >= AW'(2));
    ctl.frame_end = (CW'(out_col) == w_minus1) && (HW'(out_row) == h_minus1);
  end

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    pend_next    = pend;
    out_col_next = out_col;
    out_row_next = out_row;
    if (restart) begin
      in_col_next  = '0;
      in_row_next  = '0;
      pend_next    = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (go) begin
      if (!drain) begin
        if (CW'(in_col) == w_minus1) begin
          in_col_next = '0;
          in_row_next = (HW'(in_row) == h_minus1) ? '0 : in_row + RW'(1);
        end else begin
          in_col_next = in_col + AW'(1);
        end
        if (!pend_full) begin
          pend_next = pend + CW'(1);
        end
      end else if (drain_live) begin
        pend_next = pend - CW'(1);
      end
      if (ctl.emit) begin
        if (CW'(out_col) == w_minus1) begin
          out_col_next = '0;
          out_row_next = (HW'(out_row) == h_minus1) ? '0 : out_row + RW'(1);
        end else begin
          out_col_next = out_col + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      pend    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      pend    <= pend_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // read addresses follow the next state so data is ready with the next transaction
  assign vc_next     = w_plus1 - pend_next;
  assign wr_addr     = in_col;
  assign rd_addr_col = in_col_next;
  assign rd_addr_vc  = (vc_next < eff_w) ? AW'(vc_next) : '0;

  `RGBEM_ASSERT_NOW(a_pend_bound, clk, rst, 1'b1, pend <= w_plus1)
  `RGBEM_ASSERT_NEXT(a_frame_wrap, clk, rst, ctl.emit && ctl.frame_end && !restart,
                     (out_col == '0) && (out_row == '0))
  `RGBEM_ASSERT_NEXT(a_pixel_pend, clk, rst, go && !drain && !restart, pend != '0)
  `RGBEM_ASSERT_NEXT(a_drain_holds_pos, clk, rst, go && drain && pos0 && !restart,
                     (in_col == '0) && (in_row == '0))

endmodule

`default_nettype wire

/* design/rgbem_mask.sv */
// ----------------------------------------------------------------------------
// rgbem_mask
// 3x3 mask sums per channel, wrapped to 8 bits, with border and passthrough.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbem_mask (
  input  wire rgbem_pkg::win_t                win,
  input  wire logic [rgbem_pkg::KIND_W-1:0]   kind,
  input  wire logic                           interior,
  output rgbem_pkg::pix_t                     pix
);

  localparam int CH = rgbem_pkg::CH_W;

  logic [CH-1:0] v [3][3][3];
  logic [CH-1:0] sum [3];
  logic          pass;

  always_comb begin
    pass = 1'b0;
    case (kind)
      rgbem_pkg::MASK_LAPLACE4,
      rgbem_pkg::MASK_LAPLACE8,
      rgbem_pkg::MASK_VPREWITT,
      rgbem_pkg::MASK_HPREWITT: pass = 1'b0;
      default:                  pass = 1'b1;
    endcase
  end

  // all arithmetic is modulo 256, matching the low-byte truncation
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          v[ch][r][c] = win[r][c][CH*ch +: CH];
        end
      end
      case (kind)
        rgbem_pkg::MASK_LAPLACE4: begin
          sum[ch] = (v[ch][1][1] << 2) - v[ch][0][1] - v[ch][1][0]
                    - v[ch][1][2] - v[ch][2][1];
        end
        rgbem_pkg::MASK_LAPLACE8: begin
          sum[ch] = (v[ch][1][1] << 3) - v[ch][0][0] - v[ch][0][1] - v[ch][0][2]
                    - v[ch][1][0] - v[ch][1][2] - v[ch][2][0] - v[ch][2][1]
                    - v[ch][2][2];
        end
        rgbem_pkg::MASK_VPREWITT: begin
          sum[ch] = v[ch][2][0] + v[ch][2][1] + v[ch][2][2]
                    - v[ch][0][0] - v[ch][0][1] - v[ch][0][2];
        end
        rgbem_pkg::MASK_HPREWITT: begin
          sum[ch] = v[ch][0][2] + v[ch][1][2] + v[ch][2][2]
                    - v[ch][0][0] - v[ch][1][0] - v[ch][2][0];
        end
        default: sum[ch] = v[ch][1][1];
      endcase
      if (pass) begin
        pix[CH*ch +: CH] = v[ch][1][1];
      end else begin
        pix[CH*ch +: CH] = interior ? sum[ch] : '0;
      end
    end
  end

endmodule

`default_nettype wire
